// ===== src/whp_pkg.sv =====
package whp_pkg;

    // Header window and derived widths
    localparam int HEADER_WINDOW = 512;
    localparam int POS_W         = $clog2(HEADER_WINDOW + 1);
    localparam int OFFSET_W      = 10;

    typedef logic [POS_W-1:0] t_pos;

    // Chunk tags, compared big-endian
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] TAG_FACT = 32'h6661_6374;

    // Format field values
    localparam logic [15:0] FMT_PCM       = 16'h0001;
    localparam logic [31:0] FMT_PLAIN_LEN = 32'h0000_0010;
    localparam logic [15:0] BITS_PCM16    = 16'd16;
    localparam logic [15:0] EXTRA_NONE    = 16'h0000;

    // Byte positions at which a field is complete
    localparam t_pos POS_RIFF_TAG   = t_pos'(3);
    localparam t_pos POS_RIFF_SIZE  = t_pos'(7);
    localparam t_pos POS_WAVE_TAG   = t_pos'(11);
    localparam t_pos POS_FMT_TAG    = t_pos'(15);
    localparam t_pos POS_FMT_LEN    = t_pos'(19);
    localparam t_pos POS_FORMAT     = t_pos'(21);
    localparam t_pos POS_CHANNELS   = t_pos'(23);
    localparam t_pos POS_RATE       = t_pos'(27);
    localparam t_pos POS_BYTE_RATE  = t_pos'(31);
    localparam t_pos POS_ALIGN      = t_pos'(33);
    localparam t_pos POS_BITS       = t_pos'(35);
    localparam t_pos PLAIN_DATA_POS = t_pos'(36);
    localparam t_pos POS_EXTRA_CNT  = t_pos'(37);
    localparam t_pos POS_FACT_TAG   = t_pos'(41);
    localparam t_pos POS_FACT_SIZE  = t_pos'(45);
    localparam t_pos FACT_DATA_BASE = t_pos'(46);
    localparam t_pos MAX_DATA_POS   = t_pos'(HEADER_WINDOW - 8);

    // Largest fact payload that still leaves the data chunk header in the window
    localparam logic [31:0] FACT_SIZE_MAX = 32'(HEADER_WINDOW - 54);

    typedef enum logic [3:0] {
        ST_VALID     = 4'd0,
        ST_RIFF      = 4'd1,
        ST_WAVE      = 4'd2,
        ST_FMT_ID    = 4'd3,
        ST_FORMAT    = 4'd4,
        ST_BITS      = 4'd5,
        ST_DATA_ID   = 4'd6,
        ST_EXTRA     = 4'd7,
        ST_FACT_ID   = 4'd8
    } t_status;

    typedef struct packed {
        logic [7:0] hdr_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [15:0]           num_channels;
        logic [31:0]           sample_rate;
        logic [31:0]           byte_rate;
        logic [15:0]           block_align;
        logic [15:0]           sample_bits;
        logic [31:0]           riff_size;
        logic [31:0]           data_size;
        logic [OFFSET_W-1:0]   data_offset;
    } t_result;

    // Reassemble little-endian numbers from the big-endian shift word
    function automatic logic [31:0] le32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [15:0] le16(input logic [31:0] w);
        return {w[7:0], w[15:8]};
    endfunction

endpackage

// ===== src/whp_in_stage.sv =====
module whp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  whp_pkg::t_in_item i_item,
    input  logic              i_adv,
    output logic              o_fire,
    output whp_pkg::t_in_item o_item
);
    import whp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Hold the byte only while the result side cannot move
    assign o_stall = r_valid && !i_adv;
    assign o_fire  = r_valid && i_adv;
    assign o_item  = r_item;

    // Register the incoming transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== src/whp_parse.sv =====
module whp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  whp_pkg::t_in_item i_item,
    output logic              o_res_valid,
    output whp_pkg::t_result  o_res
);
    import whp_pkg::*;

    logic        r_done;
    t_pos        r_pos;
    logic [31:0] r_word;
    logic        r_extra;
    t_pos        r_dtag;
    logic [15:0] r_chan;
    logic [31:0] r_rate;
    logic [31:0] r_brate;
    logic [15:0] r_align;
    logic [15:0] r_bits;
    logic [31:0] r_riff;

    logic        n_done;
    t_pos        n_pos;
    logic [31:0] n_word;
    logic        n_extra;
    t_pos        n_dtag;
    logic [15:0] n_chan;
    logic [31:0] n_rate;
    logic [31:0] n_brate;
    logic [15:0] n_align;
    logic [15:0] n_bits;
    logic [31:0] n_riff;

    t_pos        p;
    logic        hit;
    t_status     status;
    logic [31:0] dsize;
    t_pos        doff;

    // Step the parse by one byte
    always_comb begin
        n_done  = r_done;
        n_pos   = r_pos;
        n_word  = r_word;
        n_extra = r_extra;
        n_dtag  = r_dtag;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_brate = r_brate;
        n_align = r_align;
        n_bits  = r_bits;
        n_riff  = r_riff;
        p       = '0;
        hit     = 1'b0;
        status  = ST_VALID;
        dsize   = '0;
        doff    = '0;
        if (i_fire && (i_item.first_byte || !r_done)) begin
            // Restart on the first byte of a file
            if (i_item.first_byte) begin
                n_done  = 1'b0;
                n_pos   = '0;
                n_word  = '0;
                n_extra = 1'b0;
                n_dtag  = PLAIN_DATA_POS;
                n_chan  = '0;
                n_rate  = '0;
                n_brate = '0;
                n_align = '0;
                n_bits  = '0;
                n_riff  = '0;
            end
            n_word = {n_word[23:0], i_item.hdr_byte};
            p      = n_pos;
            n_pos  = p + t_pos'(1);

            // Fixed fields of the RIFF and fmt headers
            case (p)
                POS_RIFF_TAG: begin
                    if (n_word != TAG_RIFF) begin
                        hit = 1'b1; status = ST_RIFF;
                    end
                end
                POS_RIFF_SIZE: n_riff = le32(n_word);
                POS_WAVE_TAG: begin
                    if (n_word != TAG_WAVE) begin
                        hit = 1'b1; status = ST_WAVE;
                    end
                end
                POS_FMT_TAG: begin
                    if (n_word != TAG_FMT) begin
                        hit = 1'b1; status = ST_FMT_ID;
                    end
                end
                POS_FMT_LEN: begin
                    if (le32(n_word) != FMT_PLAIN_LEN) begin
                        n_extra = 1'b1;
                    end
                end
                POS_FORMAT: begin
                    if (le16(n_word) != FMT_PCM) begin
                        hit = 1'b1; status = ST_FORMAT;
                    end
                end
                POS_CHANNELS:  n_chan  = le16(n_word);
                POS_RATE:      n_rate  = le32(n_word);
                POS_BYTE_RATE: n_brate = le32(n_word);
                POS_ALIGN:     n_align = le16(n_word);
                POS_BITS: begin
                    n_bits = le16(n_word);
                    if (le16(n_word) != BITS_PCM16) begin
                        hit = 1'b1; status = ST_BITS;
                    end
                end
                default: ;
            endcase

            // Extra format bytes, fact chunk, then the data chunk header
            if (!hit && p >= PLAIN_DATA_POS) begin
                if (n_extra && p <= POS_FACT_SIZE) begin
                    if (p == POS_EXTRA_CNT) begin
                        if (le16(n_word) != EXTRA_NONE) begin
                            hit = 1'b1; status = ST_EXTRA;
                        end
                    end else if (p == POS_FACT_TAG) begin
                        if (n_word != TAG_FACT) begin
                            hit = 1'b1; status = ST_FACT_ID;
                        end
                    end else if (p == POS_FACT_SIZE) begin
                        if (le32(n_word) > FACT_SIZE_MAX) begin
                            hit = 1'b1; status = ST_DATA_ID;
                        end else begin
                            n_dtag = t_pos'(le32(n_word)) + FACT_DATA_BASE;
                        end
                    end
                end else if (p == n_dtag + t_pos'(3)) begin
                    if (n_word != TAG_DATA) begin
                        hit = 1'b1; status = ST_DATA_ID;
                    end
                end else if (p == n_dtag + t_pos'(7)) begin
                    hit    = 1'b1;
                    status = ST_VALID;
                    dsize  = le32(n_word);
                    doff   = n_dtag + t_pos'(8);
                end
            end

            if (hit) begin
                n_done = 1'b1;
            end
        end
    end

    // Build the verdict from the updated captures
    always_comb begin
        o_res_valid        = hit;
        o_res.status       = status;
        o_res.num_channels = n_chan;
        o_res.sample_rate  = n_rate;
        o_res.byte_rate    = n_brate;
        o_res.block_align  = n_align;
        o_res.sample_bits  = n_bits;
        o_res.riff_size    = n_riff;
        o_res.data_size    = dsize;
        o_res.data_offset  = OFFSET_W'(doff);
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b1;
            r_pos   <= '0;
            r_extra <= 1'b0;
            r_dtag  <= PLAIN_DATA_POS;
        end else begin
            r_done  <= n_done;
            r_pos   <= n_pos;
            r_extra <= n_extra;
            r_dtag  <= n_dtag;
        end
        r_word  <= n_word;
        r_chan  <= n_chan;
        r_rate  <= n_rate;
        r_brate <= n_brate;
        r_align <= n_align;
        r_bits  <= n_bits;
        r_riff  <= n_riff;
    end

    a_dtag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dtag >= PLAIN_DATA_POS && r_dtag <= MAX_DATA_POS)
        else $error("data tag position outside header window");

    a_verdict_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_done)
        else $error("parse still open after a verdict");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(i_fire && i_item.first_byte)) |=> r_done)
        else $error("parse left idle without a first byte");

endmodule

// ===== src/whp_out_stage.sv =====
module whp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  whp_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output whp_pkg::t_result o_res
);
    import whp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result is transferred this cycle
    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== src/wav_header_parser_unit.sv =====
// Path: the byte that completes a verdict is held in the input register, and the verdict
// lands in the result register, which drives the outputs.
// Throughput: one header byte per cycle if not stalled; one byte of parse logic in between.
// Stalls: the input stalls only while a verdict waits in the result register under i_stall.
// Reset (i_rst_n low, synchronous): pipeline emptied and the parser idle; bytes are
// ignored until one arrives with i_first_byte set.
module wav_header_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_hdr_byte,
    input  logic        i_first_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [15:0] o_num_channels,
    output logic [31:0] o_sample_rate,
    output logic [31:0] o_byte_rate,
    output logic [15:0] o_block_align,
    output logic [15:0] o_sample_bits,
    output logic [31:0] o_riff_size,
    output logic [31:0] o_data_size,
    output logic [whp_pkg::OFFSET_W-1:0] o_data_offset
);
    import whp_pkg::*;

    t_in_item w_in;
    t_in_item w_item;
    logic     w_fire;
    logic     w_adv;
    logic     w_res_valid;
    t_result  w_res;
    t_result  w_out;

    assign w_in.hdr_byte   = i_hdr_byte;
    assign w_in.first_byte = i_first_byte;

    whp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (w_in),
        .i_adv   (w_adv),
        .o_fire  (w_fire),
        .o_item  (w_item)
    );

    whp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    whp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_free  (w_adv),
        .o_valid (o_valid),
        .o_res   (w_out)
    );

    // Unpack the result register onto the ports
    assign o_status       = 4'(w_out.status);
    assign o_num_channels = w_out.num_channels;
    assign o_sample_rate  = w_out.sample_rate;
    assign o_byte_rate    = w_out.byte_rate;
    assign o_block_align  = w_out.block_align;
    assign o_sample_bits  = w_out.sample_bits;
    assign o_riff_size    = w_out.riff_size;
    assign o_data_size    = w_out.data_size;
    assign o_data_offset  = w_out.data_offset;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input held back while the result register could move");

endmodule
